// File: sv/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants for the voice allocator: slot count, command
// codes, controller numbers and the voice memory word.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

	localparam int VOICE_SLOTS = 4;
	localparam int SLOT_W      = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

	localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
	localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
	localparam logic [2:0] CMD_CONTROL  = 3'd2;
	localparam logic [2:0] CMD_STOP     = 3'd3;
	localparam logic [2:0] CMD_CONTINUE = 3'd4;
	localparam logic [2:0] CMD_RESET    = 3'd5;

	localparam logic [6:0] CC_SUSTAIN       = 7'h40;
	localparam logic [6:0] CC_SOUND_OFF     = 7'h78;
	localparam logic [6:0] CC_RESET_CTRL    = 7'h79;
	localparam logic [6:0] CC_NOTES_OFF     = 7'h7B;
	localparam logic [6:0] CC_OMNI_OFF      = 7'h7C;
	localparam logic [6:0] PEDAL_THRESHOLD  = 7'd64;
	localparam logic [15:0] TIME_BOUND      = 16'hFFFF;

	typedef struct packed {
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] start_time;
	} voice_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		voice_t            data;
	} voice_wr_t;

endpackage

`default_nettype wire

// File: sv/mva_voice_ram.sv
// ----------------------------------------------------------------------------
// mva_voice_ram
// Voice slot memory: note, level and start time per slot. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_voice_ram
	import mva_pkg::*;
(
	input  wire logic              clk,
	input  wire voice_wr_t         wr,
	input  wire logic [SLOT_W-1:0] raddr,
	output voice_t                 rdata
);

	voice_t mem [VOICE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/midi_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator_unit
// Polyphonic voice allocator with oldest-note stealing and sustain pedal.
//
// Input channel (in_valid/in_ready) takes one MIDI event word: command,
// note or controller number, amount and arrival time. Output channel
// (out_valid/out_ready) returns exactly one result word per event.
// Note-on and note-off events scan the voice memory one slot per cycle
// (one read port with registered read data), then pass a drain step while
// the last read returns, and write their result word in the finish step.
// Every other event goes straight from acceptance to the finish step.
// The block works on one event at a time: the next event is accepted only
// after the last one has left the finish step. in_ready is high whenever
// no event is in progress, also while a previous result still waits in the
// output register.
// If the receiver stalls, the finished event waits in its final step until
// the output register is free; its state update is made at that moment.
// Reset clears the playing and held flags, the pedal, the state, the scan
// counter and out_valid; the event word, result fields and voice memory
// are left as they are, and memory data is only used for playing slots.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_voice_allocator_unit
	import mva_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [6:0]  note_or_controller,
	input  wire logic [6:0]  amount,
	input  wire logic [15:0] arrival_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             refresh,
	output logic             stop_timers,
	output logic [1:0]       slot,
	output logic             slot_written,
	output logic [6:0]       slot_note,
	output logic [6:0]       slot_level,
	output logic [3:0]       playing_mask,
	output logic [3:0]       held_mask,
	output logic             pedal_state
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICE_SLOTS - 1);

	state_t state_q;

	// event word
	logic [2:0]  cmd_q;
	logic [6:0]  num_q;
	logic [6:0]  amt_q;
	logic [15:0] time_q;

	// slot flags
	logic [VOICE_SLOTS-1:0] playing_q;
	logic [VOICE_SLOTS-1:0] held_q;
	logic                   pedal_q;

	// scan
	logic [SLOT_W-1:0] cnt_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	voice_t            rdata;
	logic              match_found_q;
	logic [SLOT_W-1:0] match_idx_q;
	logic [6:0]        match_vel_q;
	logic [15:0]       best_time_q;
	logic [SLOT_W-1:0] old_idx_q;

	voice_wr_t         wr;
	logic [SLOT_W-1:0] raddr;

	// finish step
	logic                   fire;
	logic                   free_found;
	logic [SLOT_W-1:0]      free_idx;
	logic [VOICE_SLOTS-1:0] play_n;
	logic [VOICE_SLOTS-1:0] held_n;
	logic                   pedal_n;
	logic                   refresh_n;
	logic                   stop_n;
	logic                   written_n;
	logic [SLOT_W-1:0]      sel_n;
	logic [6:0]             note_n;
	logic [6:0]             level_n;
	logic [31:0]            sel_ext;
	logic [VOICE_SLOTS+3:0] play_ext;
	logic [VOICE_SLOTS+3:0] held_ext;

	logic in_fire;
	logic is_note_cmd;
	logic [2:0] cmd_in;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fire     = (state_q == ST_FINISH) && (!out_valid || out_ready);
	assign raddr    = cnt_q;

	// note-on at zero level is a note-off
	assign cmd_in = (command == CMD_NOTE_ON && amount == 7'd0) ? CMD_NOTE_OFF : command;
	assign is_note_cmd = (cmd_in == CMD_NOTE_ON) || (cmd_in == CMD_NOTE_OFF);

	mva_voice_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	// first free slot from the flags
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
			if (!playing_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		play_n    = playing_q;
		held_n    = held_q;
		pedal_n   = pedal_q;
		refresh_n = 1'b0;
		stop_n    = 1'b0;
		written_n = 1'b0;
		sel_n     = '0;
		note_n    = '0;
		level_n   = '0;
		wr.en     = 1'b0;
		wr.addr   = '0;
		wr.data   = '{pitch: num_q, velocity: amt_q, start_time: time_q};

		unique case (cmd_q)
			CMD_NOTE_ON: begin
				if (match_found_q) begin
					sel_n = match_idx_q;
				end else if (free_found) begin
					sel_n = free_idx;
				end else begin
					sel_n = old_idx_q;
				end
				play_n[sel_n] = 1'b1;
				held_n[sel_n] = 1'b0;
				wr.en         = fire;
				wr.addr       = sel_n;
				written_n     = 1'b1;
				refresh_n     = 1'b1;
				note_n        = num_q;
				level_n       = amt_q;
			end
			CMD_NOTE_OFF: begin
				if (match_found_q) begin
					sel_n = match_idx_q;
					if (pedal_q) begin
						held_n[sel_n] = 1'b1;
					end else begin
						play_n[sel_n] = 1'b0;
						held_n[sel_n] = 1'b0;
					end
					written_n = 1'b1;
					refresh_n = 1'b1;
					note_n    = num_q;
					level_n   = match_vel_q;
				end
			end
			CMD_CONTROL: begin
				if (num_q == CC_SOUND_OFF || num_q == CC_RESET_CTRL ||
				    num_q == CC_NOTES_OFF || num_q == CC_OMNI_OFF) begin
					stop_n = 1'b1;
				end
				if (num_q == CC_SUSTAIN) begin
					if (amt_q < PEDAL_THRESHOLD) begin
						pedal_n   = 1'b0;
						play_n    = playing_q & ~held_q;
						held_n    = '0;
						refresh_n = 1'b1;
					end else begin
						pedal_n = 1'b1;
					end
				end
			end
			CMD_STOP: begin
				stop_n = 1'b1;
			end
			CMD_CONTINUE: begin
				refresh_n = 1'b1;
			end
			CMD_RESET: begin
				stop_n  = 1'b1;
				play_n  = '0;
				held_n  = '0;
				pedal_n = 1'b0;
			end
			default: begin
			end
		endcase

		sel_ext  = 32'(sel_n);
		play_ext = {4'b0, play_n};
		held_ext = {4'b0, held_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			playing_q     <= '0;
			held_q        <= '0;
			pedal_q       <= 1'b0;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			match_found_q <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			rd_idx_s1 <= cnt_q;

			if (out_valid && out_ready && !fire) begin
				out_valid <= 1'b0;
			end

			// fold in one slot per cycle as read data returns
			if (rd_vld_s1 && playing_q[rd_idx_s1]) begin
				if (!match_found_q && rdata.pitch == num_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= rd_idx_s1;
					match_vel_q   <= rdata.velocity;
				end
				if (rdata.start_time < best_time_q) begin
					best_time_q <= rdata.start_time;
					old_idx_q   <= rd_idx_s1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q         <= cmd_in;
						num_q         <= note_or_controller;
						amt_q         <= amount;
						time_q        <= arrival_time;
						cnt_q         <= '0;
						match_found_q <= 1'b0;
						best_time_q   <= TIME_BOUND;
						old_idx_q     <= '0;
						state_q       <= is_note_cmd ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fire) begin
						playing_q    <= play_n;
						held_q       <= held_n;
						pedal_q      <= pedal_n;
						out_valid    <= 1'b1;
						refresh      <= refresh_n;
						stop_timers  <= stop_n;
						slot_written <= written_n;
						slot         <= sel_ext[1:0];
						slot_note    <= note_n;
						slot_level   <= level_n;
						playing_mask <= play_ext[3:0];
						held_mask    <= held_ext[3:0];
						pedal_state  <= pedal_n;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/mva_checker.sv
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks for the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        refresh,
	input wire logic        slot_written,
	input wire logic [1:0]  slot,
	input wire logic [6:0]  slot_note,
	input wire logic [6:0]  slot_level,
	input wire logic [3:0]  playing_mask,
	input wire logic [3:0]  held_mask,
	input wire logic        pedal_state
);

	// stalled result stays valid with slot and held mask unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(held_mask))
		else $error("result word changed while stalled");

	// a changed slot always asks for a refresh
	a_written_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot_written |-> refresh)
		else $error("slot written without refresh");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !slot_written |-> slot == 2'd0 && slot_note == 7'd0 && slot_level == 7'd0)
		else $error("slot fields not zero without a write");

	// only playing slots can be held, and only with the pedal down
	a_held_playing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (held_mask & ~playing_mask) == 4'd0)
		else $error("held slot is not playing");

	a_held_pedal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held_mask != 4'd0 |-> pedal_state)
		else $error("held slot with pedal up");

endmodule

bind midi_voice_allocator_unit mva_checker u_mva_checker (.*);

`default_nettype wire
